// ----- rtl/pwm_pulse_width_mapper_assert.svh -----
// ----------------------------------------------------------------------------
// PWM pulse width mapper assertion macros
// Concurrent checks sampled on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PWM_PULSE_WIDTH_MAPPER_ASSERT_SVH
`define PWM_PULSE_WIDTH_MAPPER_ASSERT_SVH

// same-cycle implication
`define PWMPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWMPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pwmpm_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM pulse width mapper package
// Widths, register indexes, clamp select codes and reciprocal constants.
// ----------------------------------------------------------------------------
package pwmpm_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_W    = 16;
	localparam int TICK_W     = 19;
	localparam int LIMIT_W    = 17;
	localparam int CMD_W      = 16;
	localparam int CHAN_W     = 2;
	localparam int SPAN_W     = 20;
	localparam int PROD_W     = 36;
	localparam int NUM_W      = 37;
	localparam int SCALED_W   = 32;
	localparam int LIM_X_W    = 30;
	localparam int FRAC_W     = 30;
	localparam int CMP_W      = 17;

	localparam logic [CFG_ADDR_W-1:0] REG_MIN_WIDTH    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_WIDTH    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CENTER_WIDTH = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_TOP   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_CHECKED_MODE = 3'd4;

	localparam logic [WIDTH_W-1:0] TOP_RESET = 16'd10239;

	// ticks = floor((400*d + 39) / 78), exact for 25-bit dividends
	localparam logic [24:0] CONV_SCALE  = 25'd400;
	localparam logic [24:0] CONV_BIAS   = 25'd39;
	localparam logic [25:0] CONV_MUL    = 26'd55063684;
	localparam int          CONV_SHIFT  = 32;

	// round(n / 10000) = floor(((n + 5000) >> 4) / 625), exact for 26-bit values
	localparam logic [31:0] FULL_SCALE  = 32'd10000;
	localparam logic [FRAC_W-1:0] HALF_SCALE = 30'd5000;
	localparam logic [26:0] RND_MUL     = 27'd109951163;
	localparam int          RND_SHIFT   = 36;

	typedef logic [1:0] clamp_sel_t;
	localparam clamp_sel_t SEL_NUM = 2'd0;
	localparam clamp_sel_t SEL_LO  = 2'd1;
	localparam clamp_sel_t SEL_HI  = 2'd2;
	localparam clamp_sel_t SEL_LIM = 2'd3;

endpackage

// ----- rtl/pwm_pulse_width_mapper.sv -----
// ----------------------------------------------------------------------------
// PWM pulse width mapper
// Maps a signed 0.01 % command onto an RC pulse compare value in timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tdata[15:0] command (signed),
//   tuser[1:0] channel. m_axis returns one beat per command: tdata[16:0]
//   compare value, tuser[1:0] channel, tuser[2] status (1 = width beyond
//   period in checked mode, compare value 0).
//   cfg_we/cfg_addr/cfg_wdata write min, max, center width, period top and
//   checked mode; widths are converted to ticks as they are written. Write
//   only while no beat is in flight.
//   Stages: input register, then multiply, clamp, and round through the
//   output register. Throughput: one command per cycle while the receiver
//   does not stall; the stages are set by one signed multiplier and one
//   reciprocal multiplier for the final rounding.
//   Reset clears all valid flags and loads the register reset values.
//   When the receiver stalls, the output holds and the stages behind it
//   keep filling their empty slots before s_axis_tready drops.
// ----------------------------------------------------------------------------
module pwm_pulse_width_mapper
	import pwmpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // [15:0] command
	input  logic [1:0]            s_axis_tuser,  // [1:0] channel
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // [16:0] compare_value
	output logic [2:0]            m_axis_tuser   // [1:0] out_channel, [2] status
);

	logic [TICK_W-1:0]   lo_q, hi_q, mid_q;
	logic [WIDTH_W-1:0]  top_q;
	logic                checked_q;
	logic [SCALED_W-1:0] lo_x_q, hi_x_q, mid_x_q;
	logic [LIM_X_W-1:0]  lim_x_q;
	logic                err_q;
	logic [LIMIT_W-1:0]  limit;

	logic [24:0]         conv_x;
	logic [50:0]         conv_prod;
	logic [TICK_W-1:0]   conv_ticks;

	logic                v_s1, v_s2, v_s3, out_valid_q;
	logic                rdy_s1, rdy_s2, rdy_s3, rdy_out;

	logic signed [CMD_W-1:0]  cmd_s1;
	logic [CHAN_W-1:0]        chan_s1, chan_s2, chan_s3;
	logic signed [SPAN_W-1:0] span;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [NUM_W-1:0]  num, lo_xs, hi_xs, lim_xs;
	logic                     below_lo, above_hi, above_lim;
	logic                     lo_over, hi_over;
	clamp_sel_t               sel, sel_s3;
	logic [FRAC_W-1:0]        frac_s3, frac_sum;
	logic [25:0]              rnd_y;
	logic [52:0]              rnd_prod;
	logic [CMP_W-1:0]         rnd_ticks, cmp_val;

	logic [CMP_W-1:0]         out_value_q;
	logic [CHAN_W-1:0]        out_chan_q;
	logic                     out_status_q;

	// width to ticks on the write path
	assign conv_x     = 25'(cfg_wdata) * CONV_SCALE + CONV_BIAS;
	assign conv_prod  = 51'(conv_x) * 51'(CONV_MUL);
	assign conv_ticks = conv_prod[CONV_SHIFT +: TICK_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q      <= '0;
			hi_q      <= '0;
			mid_q     <= '0;
			top_q     <= TOP_RESET;
			checked_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MIN_WIDTH:    lo_q      <= conv_ticks;
				REG_MAX_WIDTH:    hi_q      <= conv_ticks;
				REG_CENTER_WIDTH: mid_q     <= conv_ticks;
				REG_PERIOD_TOP:   top_q     <= cfg_wdata[WIDTH_W-1:0];
				REG_CHECKED_MODE: checked_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign limit = LIMIT_W'(top_q) + LIMIT_W'(1);

	// scaled bounds and error flag, settled long before any beat reaches them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_x_q  <= '0;
			hi_x_q  <= '0;
			mid_x_q <= '0;
			lim_x_q <= LIM_X_W'((LIMIT_W'(TOP_RESET) + LIMIT_W'(1)) * 30'd10000);
			err_q   <= 1'b0;
		end else begin
			lo_x_q  <= SCALED_W'(lo_q) * FULL_SCALE;
			hi_x_q  <= SCALED_W'(hi_q) * FULL_SCALE;
			mid_x_q <= SCALED_W'(mid_q) * FULL_SCALE;
			lim_x_q <= LIM_X_W'(limit) * LIM_X_W'(FULL_SCALE);
			err_q   <= checked_q && ((lo_q > TICK_W'(limit)) || (hi_q > TICK_W'(limit))
				|| (mid_q > TICK_W'(limit)));
		end
	end

	// stage handshake
	assign rdy_out       = !out_valid_q || m_axis_tready;
	assign rdy_s3        = !v_s3 || rdy_out;
	assign rdy_s2        = !v_s2 || rdy_s3;
	assign rdy_s1        = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= s_axis_tvalid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cmd_s1  <= s_axis_tdata[CMD_W-1:0];
			chan_s1 <= s_axis_tuser[CHAN_W-1:0];
		end
	end

	// stage 2: span times command
	assign span = cmd_s1[CMD_W-1] ? (SPAN_W'($signed({1'b0, mid_q})) - SPAN_W'($signed({1'b0, lo_q})))
		: (SPAN_W'($signed({1'b0, hi_q})) - SPAN_W'($signed({1'b0, mid_q})));

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			prod_s2 <= PROD_W'(span) * PROD_W'(cmd_s1);
			chan_s2 <= chan_s1;
		end
	end

	// stage 3: exact clamp decision
	assign num    = NUM_W'($signed({1'b0, mid_x_q})) + NUM_W'(prod_s2);
	assign lo_xs  = NUM_W'($signed({1'b0, lo_x_q}));
	assign hi_xs  = NUM_W'($signed({1'b0, hi_x_q}));
	assign lim_xs = NUM_W'($signed({1'b0, lim_x_q}));

	assign below_lo  = num < lo_xs;
	assign above_hi  = num > hi_xs;
	assign above_lim = num > lim_xs;
	assign lo_over   = lo_q > TICK_W'(limit);
	assign hi_over   = hi_q > TICK_W'(limit);

	always_comb begin
		if (below_lo) begin
			sel = lo_over ? SEL_LIM : SEL_LO;
		end else if (above_hi) begin
			sel = hi_over ? SEL_LIM : SEL_HI;
		end else begin
			sel = above_lim ? SEL_LIM : SEL_NUM;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sel_s3  <= sel;
			frac_s3 <= num[FRAC_W-1:0];
			chan_s3 <= chan_s2;
		end
	end

	// output: round to nearest and select
	assign frac_sum  = frac_s3 + HALF_SCALE;
	assign rnd_y     = frac_sum[FRAC_W-1:4];
	assign rnd_prod  = 53'(rnd_y) * 53'(RND_MUL);
	assign rnd_ticks = rnd_prod[RND_SHIFT +: CMP_W];

	always_comb begin
		case (sel_s3)
			SEL_NUM: cmp_val = rnd_ticks;
			SEL_LO:  cmp_val = CMP_W'(lo_q);
			SEL_HI:  cmp_val = CMP_W'(hi_q);
			SEL_LIM: cmp_val = limit;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_value_q  <= err_q ? '0 : cmp_val;
			out_status_q <= err_q;
			out_chan_q   <= chan_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_value_q};
	assign m_axis_tuser  = {out_status_q, out_chan_q};

`include "pwm_pulse_width_mapper_assert.svh"

	`PWMPM_ASSERT_NOW(a_err_zero, out_valid_q && out_status_q, out_value_q == '0, "error beat carries a nonzero compare value")
	`PWMPM_ASSERT_NOW(a_err_mode, out_valid_q && out_status_q, checked_q, "error beat outside checked mode")
	`PWMPM_ASSERT_NOW(a_in_period, out_valid_q && !out_status_q, out_value_q <= limit, "compare value beyond period")
	`PWMPM_ASSERT_NEXT(a_accept_s1, s_axis_tvalid && s_axis_tready, v_s1, "accepted beat lost at stage 1")
	`PWMPM_ASSERT_NEXT(a_s3_out, v_s3 && rdy_out, out_valid_q, "stage 3 beat lost at output")

endmodule
